### rtl/morse_letter_pulse_encoder_top_macros.svh
// assertion macros shared by the checker
`ifndef MORSE_LETTER_PULSE_ENCODER_TOP_MACROS_SVH
`define MORSE_LETTER_PULSE_ENCODER_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define MLPE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define MLPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mlpe_pkg.sv
// shared types, constants and morse table for the pulse encoder
`timescale 1ns / 1ps
package mlpe_pkg;

  localparam int CHAR_W = 8;
  localparam int DUR_W  = 16;
  localparam int CNT_W  = 3;
  localparam int BITS_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_Z = 8'h7A;

  localparam logic [DUR_W-1:0] RST_DOT_TIME    = 16'd450;
  localparam logic [DUR_W-1:0] RST_DASH_TIME   = 16'd1000;
  localparam logic [DUR_W-1:0] RST_ELEMENT_GAP = 16'd450;
  localparam logic [DUR_W-1:0] RST_LETTER_GAP  = 16'd1000;
  localparam logic [DUR_W-1:0] RST_WORD_GAP    = 16'd1200;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    REG_DOT_TIME    = 3'd0,
    REG_DASH_TIME   = 3'd1,
    REG_ELEMENT_GAP = 3'd2,
    REG_LETTER_GAP  = 3'd3,
    REG_WORD_GAP    = 3'd4
  } reg_idx_t;

  // upper nibble: symbol count, lower nibble: bit k set = symbol k is a dash
  localparam logic [7:0] MORSE_TABLE [0:25] = '{
    8'h22, 8'h41, 8'h45, 8'h31, 8'h10, 8'h44, 8'h33, 8'h40, 8'h20, 8'h4E,
    8'h35, 8'h42, 8'h23, 8'h21, 8'h37, 8'h46, 8'h4B, 8'h32, 8'h30, 8'h11,
    8'h34, 8'h48, 8'h36, 8'h49, 8'h4D, 8'h43
  };

  typedef struct packed {
    logic [DUR_W-1:0] dot_time;
    logic [DUR_W-1:0] dash_time;
    logic [DUR_W-1:0] element_gap;
    logic [DUR_W-1:0] letter_gap;
    logic [DUR_W-1:0] word_gap;
  } cfg_t;

  // one classified character
  typedef struct packed {
    logic              is_letter;
    logic [CNT_W-1:0]  count;
    logic [BITS_W-1:0] bits;
  } desc_t;

endpackage

### rtl/mlpe_front.sv
// front end: takes characters and classifies them into symbol descriptors
`timescale 1ns / 1ps
module mlpe_front
  import mlpe_pkg::*;
(
  input  logic              in_valid,
  input  logic [CHAR_W-1:0] in_character,
  output logic              in_stall,
  input  logic              q_full,
  output logic              q_wr,
  output desc_t             q_wr_desc
);

  logic [4:0] offset;
  logic [7:0] code;

  assign offset   = 5'(in_character - CHAR_A);
  assign in_stall = q_full;
  assign q_wr     = in_valid && !q_full;

  always_comb begin
    code      = MORSE_TABLE[offset];
    q_wr_desc = '0;
    if (in_character inside {[CHAR_A:CHAR_Z]}) begin
      q_wr_desc.is_letter = 1'b1;
      q_wr_desc.count     = code[6:4];
      q_wr_desc.bits      = code[3:0];
    end
  end

endmodule

### rtl/mlpe_queue.sv
// short first-word-fall-through queue between front and back
`timescale 1ns / 1ps
module mlpe_queue
  import mlpe_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr,
  input  desc_t wr_desc,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head
);

  desc_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (wr) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (wr && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (wr) begin
      mem_r[wptr_r] <= wr_desc;
    end
  end

endmodule

### rtl/mlpe_back.sv
// back end: walks the head descriptor and emits one pulse per beat
`timescale 1ns / 1ps
module mlpe_back
  import mlpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             q_valid,
  input  desc_t            q_head,
  output logic             q_pop,
  output logic             out_valid,
  output logic             out_level,
  output logic [DUR_W-1:0] out_duration,
  output logic             out_last_pulse,
  input  logic             out_stall
);

  typedef enum logic {
    PH_MARK,
    PH_SPACE
  } phase_t;

  phase_t           phase_r;
  logic [1:0]       sym_r;
  logic             out_valid_r;
  logic             out_level_r;
  logic [DUR_W-1:0] out_duration_r;
  logic             out_last_r;

  logic             load;
  logic             final_sym;
  logic             p_level;
  logic [DUR_W-1:0] p_dur;
  logic             p_last;

  assign load      = q_valid && (!out_valid_r || !out_stall);
  assign final_sym = ({1'b0, sym_r} + 3'd1) == q_head.count;
  assign q_pop     = load && p_last;

  always_comb begin
    p_level = 1'b0;
    p_dur   = cfg.word_gap;
    p_last  = 1'b1;
    if (q_head.is_letter) begin
      case (phase_r)
        PH_MARK: begin
          p_level = 1'b1;
          p_dur   = q_head.bits[sym_r] ? cfg.dash_time : cfg.dot_time;
          p_last  = 1'b0;
        end
        PH_SPACE: begin
          p_level = 1'b0;
          p_dur   = final_sym ? cfg.letter_gap : cfg.element_gap;
          p_last  = final_sym;
        end
        default: begin
          p_level = 1'b0;
          p_dur   = cfg.word_gap;
          p_last  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MARK;
      sym_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        if (p_last) begin
          phase_r <= PH_MARK;
          sym_r   <= '0;
        end else if (phase_r == PH_MARK) begin
          phase_r <= PH_SPACE;
        end else begin
          phase_r <= PH_MARK;
          sym_r   <= sym_r + 1'b1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (load) begin
      out_level_r    <= p_level;
      out_duration_r <= p_dur;
      out_last_r     <= p_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_level      = out_level_r;
  assign out_duration   = out_duration_r;
  assign out_last_pulse = out_last_r;

endmodule

### rtl/morse_letter_pulse_encoder_top.sv
// top level of the morse letter pulse encoder
//
//   port group  dir   handshake           beat carries
//   in_*        in    in_valid/in_stall   in_character
//   out_*       out   out_valid/out_stall out_level, out_duration, out_last_pulse
//   cfg_*       in    cfg_we              cfg_index, cfg_wdata
//
// one pulse leaves per cycle while out_stall is low: a letter gives 2 to 8 pulses, any
// other character 1; the first pulse passes through the queue and the output register
// a 2-entry descriptor queue lets new characters in while pulses are still going out
// reset loads the default durations and empties the queue and output register
// out_stall holds the output register; in_stall is high only while the queue is full
`timescale 1ns / 1ps
module morse_letter_pulse_encoder_top
  import mlpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [CHAR_W-1:0] in_character,
  output logic              in_stall,
  output logic              out_valid,
  output logic              out_level,
  output logic [DUR_W-1:0]  out_duration,
  output logic              out_last_pulse,
  input  logic              out_stall,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [DUR_W-1:0]  cfg_wdata
);

  cfg_t  cfg_r;
  logic  q_full;
  logic  q_wr;
  desc_t q_wr_desc;
  logic  q_pop;
  logic  q_valid;
  desc_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dot_time    <= RST_DOT_TIME;
      cfg_r.dash_time   <= RST_DASH_TIME;
      cfg_r.element_gap <= RST_ELEMENT_GAP;
      cfg_r.letter_gap  <= RST_LETTER_GAP;
      cfg_r.word_gap    <= RST_WORD_GAP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOT_TIME:    cfg_r.dot_time    <= cfg_wdata;
        REG_DASH_TIME:   cfg_r.dash_time   <= cfg_wdata;
        REG_ELEMENT_GAP: cfg_r.element_gap <= cfg_wdata;
        REG_LETTER_GAP:  cfg_r.letter_gap  <= cfg_wdata;
        REG_WORD_GAP:    cfg_r.word_gap    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  mlpe_front u_front (
    .in_valid     (in_valid),
    .in_character (in_character),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_wr_desc    (q_wr_desc)
  );

  mlpe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (q_wr),
    .wr_desc    (q_wr_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  mlpe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_level      (out_level),
    .out_duration   (out_duration),
    .out_last_pulse (out_last_pulse),
    .out_stall      (out_stall)
  );

endmodule

### rtl/mlpe_checker.sv
// port-level assertions for the pulse encoder, bound to the top level
`timescale 1ns / 1ps
`include "morse_letter_pulse_encoder_top_macros.svh"
module mlpe_checker
  import mlpe_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_level,
  input logic [DUR_W-1:0]  out_duration,
  input logic              out_last_pulse,
  input logic              out_stall
);

  `MLPE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_level) && $stable(out_duration) && $stable(out_last_pulse), "stalled output beat changed")
  `MLPE_ASSERT_SAME(a_mark_not_last, out_valid && out_level, !out_last_pulse, "high pulse flagged as last")
  `MLPE_ASSERT_NEXT(a_space_follows, out_valid && !out_stall && out_level, out_valid && !out_level, "high pulse not followed at once by a low pulse")

endmodule

bind morse_letter_pulse_encoder_top mlpe_checker u_mlpe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_level      (out_level),
  .out_duration   (out_duration),
  .out_last_pulse (out_last_pulse),
  .out_stall      (out_stall)
);
